/* sv/cvl_pkg.sv */
`default_nettype none
package cvl_pkg;

  localparam int STORE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int VALUE_W     = 32;

  typedef enum logic [1:0] {
    MODE_PLAY   = 2'd0,
    MODE_MUTE   = 2'd1,
    MODE_REC    = 2'd2,
    MODE_BYPASS = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic        [TIME_W-1:0]  time_now;
    logic signed [VALUE_W-1:0] live_value;
    mode_t                     mode;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      store_full;
  } out_t;

  // one stored event: time stamp and value side by side in one word
  typedef struct packed {
    logic [TIME_W-1:0]  ev_time;
    logic [VALUE_W-1:0] ev_value;
  } event_t;

  localparam int EVENT_W = $bits(event_t);

endpackage
`default_nettype wire

/* sv/control_value_looper_unit.sv */
// Channel   Direction  Payload  Handshake
// item      in         in_t     item_valid / item_stall
// result    out        out_t    result_valid / result_stall
//
// Mute, record, bypass and play on an empty store go from acceptance to the
// hold state, which loads the output register once it is free; the next item is
// taken back in idle. A play item with stored events first passes the scan
// state, which reads one event per cycle from the single event memory.
// Synchronous reset empties the store at once (fill count to zero).
// A new item is taken while the last result waits on result_stall; the
// following result is held internally until the output register frees.
`default_nettype none
module control_value_looper_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  cvl_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output cvl_pkg::out_t result
);
  import cvl_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [TIME_W-1:0]  prev_time;
  mode_t              prev_mode;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  prev_q;
  logic               rewound_q;
  logic [CNT_W-1:0]   idx;
  logic               rd_pend;
  logic [VALUE_W-1:0] res_value;
  logic               res_full;

  logic               accept;
  logic               clear;
  logic [CNT_W-1:0]   base_count;
  logic               full;
  logic               wr_en;
  logic               scan_start;
  logic               issue;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  event_t             wr_event;
  event_t             rd_event;
  logic               match;
  logic               load_out;

  assign accept     = item_valid && !item_stall;
  // entering record from any other mode empties the store
  assign clear      = (item.mode == MODE_REC) && (prev_mode != MODE_REC);
  assign base_count = clear ? '0 : count;
  assign full       = (base_count == CNT_W'(STORE_DEPTH));
  assign wr_en      = accept && (item.mode == MODE_REC) && !full;
  assign scan_start = accept && (item.mode == MODE_PLAY) && (count != '0);
  assign issue      = (state == ST_SCAN) && (idx != count);
  assign rd_en      = scan_start || issue;
  assign rd_addr    = scan_start ? '0 : idx[ADDR_W-1:0];

  assign wr_event.ev_time  = item.time_now;
  assign wr_event.ev_value = item.live_value;

  cvl_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (STORE_DEPTH)
  ) u_events (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (base_count[ADDR_W-1:0]),
    .wr_data (wr_event),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_event)
  );

  // when time did not advance, only the upper bound counts
  assign match = rd_pend && (rd_event.ev_time <= now_q)
                 && (rewound_q || (rd_event.ev_time > prev_q));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = scan_start ? ST_SCAN : ST_HOLD;
        end
      end
      ST_SCAN: begin
        if (!rd_pend) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: item_stall = 1'b0;
      ST_SCAN: item_stall = 1'b1;
      ST_HOLD: load_out   = !result_valid || !result_stall;
      default: item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      prev_time    <= '0;
      prev_mode    <= MODE_MUTE;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (accept) begin
        prev_time <= item.time_now;
        prev_mode <= item.mode;
        count     <= wr_en ? base_count + CNT_W'(1) : base_count;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_q     <= item.time_now;
      prev_q    <= prev_time;
      rewound_q <= (prev_time >= item.time_now);
      res_full  <= (item.mode == MODE_REC) && full;
      res_value <= (item.mode == MODE_MUTE) ? '0 : item.live_value;
    end else if (match) begin
      res_value <= rd_event.ev_value;
    end
    if (scan_start) begin
      idx <= CNT_W'(1);
    end else if (issue) begin
      idx <= idx + CNT_W'(1);
    end
    if (load_out) begin
      result.out_value  <= res_value;
      result.store_full <= res_full;
    end
  end

endmodule
`default_nettype wire

/* sv/cvl_ram.sv */
`default_nettype none
module cvl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import cvl_pkg::*;

  localparam int QUIET_LIMIT   = 40000;
  localparam int HOLDOFF_AFTER = 30;
  localparam int HOLDOFF_LEN   = 400;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_t;

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic item_valid   = 1'b0;
  logic item_stall;
  in_t  item         = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;

  control_value_looper_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // looper state as the block should hold it
  logic        [TIME_W-1:0]  ev_time_mem  [STORE_DEPTH];
  logic signed [VALUE_W-1:0] ev_value_mem [STORE_DEPTH];
  int                        ev_fill   = 0;
  logic        [TIME_W-1:0]  last_time = '0;
  mode_t                     last_mode = MODE_MUTE;

  in_t  item_queue[$];
  out_t expected_outputs[$];

  int errors          = 0;
  int results_checked = 0;
  int mode_seen[4]    = '{default: 0};
  int dropped_events  = 0;
  int play_hits       = 0;

  function automatic out_t looper_predict(in_t it);
    out_t r;
    logic time_held;
    logic hit;
    r.out_value  = it.live_value;
    r.store_full = 1'b0;
    hit          = 1'b0;
    if (it.mode == MODE_REC && last_mode != MODE_REC) ev_fill = 0;
    last_mode = it.mode;
    mode_seen[it.mode]++;
    case (it.mode)
      MODE_PLAY: begin
        // no advance in time: any event up to now qualifies
        time_held = (last_time >= it.time_now);
        for (int i = 0; i < ev_fill; i++) begin
          if (ev_time_mem[i] <= it.time_now && (time_held || ev_time_mem[i] > last_time)) begin
            r.out_value = ev_value_mem[i];
            hit         = 1'b1;
          end
        end
        if (hit) play_hits++;
      end
      MODE_MUTE: begin
        r.out_value = '0;
      end
      MODE_REC: begin
        if (ev_fill < STORE_DEPTH) begin
          ev_time_mem[ev_fill]  = it.time_now;
          ev_value_mem[ev_fill] = it.live_value;
          ev_fill++;
        end else begin
          r.store_full = 1'b1;
          dropped_events++;
        end
      end
      default: begin
      end
    endcase
    last_time = it.time_now;
    return r;
  endfunction

  function automatic in_t make_item(logic [TIME_W-1:0] t, logic [VALUE_W-1:0] v, mode_t m);
    in_t it;
    it.time_now   = t;
    it.live_value = v;
    it.mode       = m;
    return it;
  endfunction

  task automatic queue_item(in_t it);
    item_queue = {item_queue, it};
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) expected_outputs = {expected_outputs, looper_predict(item)};
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (item_queue.size() > 0) begin
          item       <= item_queue.pop_front();
          item_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results and stalls on a changing pattern
  stall_style_t stall_style  = STALL_NONE;
  int           style_left   = 0;
  int           holdoff_left = 0;
  bit           holdoff_done = 1'b0;
  logic         stall_next;
  out_t         want;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_checked++;
        if (expected_outputs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: value %h full %b", result.out_value, result.store_full);
        end else begin
          want = expected_outputs.pop_front();
          if (result.out_value !== want.out_value || result.store_full !== want.store_full) begin
            errors++;
            if (errors <= 10)
              $display("result %0d mismatch: expected value %h full %b, got value %h full %b",
                       results_checked, want.out_value, want.store_full,
                       result.out_value, result.store_full);
          end
        end
      end
      // hold off once for a long stretch so the block backs up to its input
      if (!holdoff_done && results_checked >= HOLDOFF_AFTER) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        stall_next = 1'b1;
      end else begin
        if (style_left == 0) begin
          stall_style = stall_style_t'($urandom_range(0, 3));
          style_left  = $urandom_range(16, 96);
        end else begin
          style_left--;
        end
        case (stall_style)
          STALL_NONE:  stall_next = 1'b0;
          STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
          default:     stall_next = ~result_stall;
        endcase
      end
      result_stall <= stall_next;
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (!(item_queue.size() == 0 && !item_valid && expected_outputs.size() == 0))
      @(posedge clk);
  endtask

  initial begin
    int                n;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] pt;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, extremes, every mode, time stalls and wrap-backs
    queue_item(make_item(32'd0, 32'h0001_0000, MODE_PLAY));
    queue_item(make_item(32'd3, 32'h7FFF_FFFF, MODE_MUTE));
    queue_item(make_item(32'd4, 32'h8000_0000, MODE_BYPASS));
    queue_item(make_item(32'd10, 32'h7FFF_FFFF, MODE_REC));
    queue_item(make_item(32'd20, 32'h8000_0000, MODE_REC));
    queue_item(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_REC));
    queue_item(make_item(32'd30, 32'h0000_0001, MODE_REC));
    queue_item(make_item(32'd15, 32'h0000_0000, MODE_PLAY));
    queue_item(make_item(32'd25, 32'h5555_5555, MODE_PLAY));
    queue_item(make_item(32'd25, 32'hAAAA_AAAA, MODE_PLAY));
    queue_item(make_item(32'd26, 32'h0F0F_0F0F, MODE_PLAY));
    queue_item(make_item(32'hFFFF_FFFF, 32'hF0F0_F0F0, MODE_PLAY));
    queue_item(make_item(32'd5, 32'h1234_5678, MODE_PLAY));
    queue_item(make_item(32'd6, 32'h8765_4321, MODE_MUTE));
    queue_item(make_item(32'd7, 32'hDEAD_BEEF, MODE_BYPASS));
    queue_item(make_item(32'd0, 32'h0000_8000, MODE_REC));
    queue_item(make_item(32'd0, 32'h1111_1111, MODE_PLAY));
    queue_item(make_item(32'd1, 32'h2222_2222, MODE_BYPASS));
    queue_item(make_item(32'hFFFF_FFFF, 32'h1234_5678, MODE_REC));
    queue_item(make_item(32'hFFFF_FFFF, 32'h3333_3333, MODE_PLAY));
    queue_item(make_item(32'd0, 32'h4444_4444, MODE_PLAY));
    wait_drained();

    // random: record runs followed by playback over the same span, with noise
    repeat (7) begin
      t = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFC0 : $urandom;
      pt = t - $urandom_range(0, 4);
      n = $urandom_range(1, 10);
      repeat (n) begin
        queue_item(make_item(t, $urandom, MODE_REC));
        t = t + $urandom_range(0, 5);
      end
      n = $urandom_range(2, 8);
      repeat (n) begin
        queue_item(make_item(pt, $urandom, MODE_PLAY));
        // mostly advance, sometimes hold or step back
        if ($urandom_range(0, 5) == 0) pt = pt - $urandom_range(0, 8);
        else pt = pt + $urandom_range(0, 6);
      end
      n = $urandom_range(0, 2);
      repeat (n) queue_item(make_item($urandom, $urandom, mode_t'($urandom_range(0, 3))));
    end
    wait_drained();

    repeat (20) @(posedge clk);
    $display("Covered %0d play, %0d mute, %0d record and %0d bypass items; %0d results checked",
             mode_seen[MODE_PLAY], mode_seen[MODE_MUTE], mode_seen[MODE_REC],
             mode_seen[MODE_BYPASS], results_checked);
    $display("Full store dropped %0d events; %0d play items took a recorded value; %0d mismatches",
             dropped_events, play_hits, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
